// File: src/assert_macros.svh
// Assertion macros shared by the RTL of the decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("forbidden state");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, expr)
`endif
`endif

// File: src/rcl_pkg.sv
// Package with item types, codes and constants of the range coded LZSS decoder.
package rcl_pkg;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last;
    logic [2:0] status;
  } out_item_t;

  localparam logic [1:0] KIND_FREQ = 2'd0;
  localparam logic [1:0] KIND_CODE = 2'd1;
  localparam logic [1:0] KIND_STEP = 2'd2;

  localparam logic [2:0] STATUS_OK    = 3'd0;
  localparam logic [2:0] STATUS_NEED  = 3'd1;
  localparam logic [2:0] STATUS_LIMIT = 3'd2;
  localparam logic [2:0] STATUS_EMPTY = 3'd3;
  localparam logic [2:0] STATUS_UNEXP = 3'd4;
  localparam logic [2:0] STATUS_ZERO  = 3'd5;

  localparam logic [31:0] NORM_TOP     = 32'h0100_0000;
  localparam logic [31:0] UNDERFLOW    = 32'h0000_2000;
  localparam logic [31:0] REBUILD_MASK = 32'h001F_FF00;
  localparam logic [11:0] POS_RESET    = 12'hFEE;

  function automatic out_item_t mk_res(logic [7:0] b, logic has, logic lst,
                                       logic [2:0] st);
    out_item_t r;
    r.out_byte = b;
    r.has_byte = has;
    r.last     = lst;
    r.status   = st;
    return r;
  endfunction

endpackage

// File: src/rcl_ram.sv
// Generic single write port RAM with one registered read port.
module rcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: src/range_coded_lzss_decoder_core.sv
// Top level of the range coded LZSS decoder: sequencer, shared divider and tables.
//
// Input items arrive on in_valid/in_stall/in_item; results leave on
// out_valid/out_stall/out_item, one output register between the two sides.
// The limit register is written on cfg_valid/cfg_ready/cfg_data, always ready.
// Send 256 frequency items, then four code items, then step and code items.
// Frequency, code and normalizing step items are answered from the idle state.
// A decoding step runs two 32-bit restoring divisions on one shared
// divider, a binary search of the cumulative table memory (a read and a
// compare per probe, eight probes), a table lookup, a multiply and an update.
// A back-reference then copies its bytes out of the window memory, each
// byte read first, then written and sent, 3 to 18 bytes.
// Reset clears all control state; the window needs no clearing pass because
// a fill count marks which entries were written, unwritten ones read as zero.
// While out_valid and out_stall are both high the sequencer waits with its next
// result and in_stall stays high; a finished result in the output register
// holds off the next item until it is taken.
module range_coded_lzss_decoder_core #(
  parameter int WINDOW_DEPTH = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  rcl_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output rcl_pkg::out_item_t out_item
);
  import rcl_pkg::*;
  `include "assert_macros.svh"

  localparam int WA = $clog2(WINDOW_DEPTH);
  localparam logic [WA-1:0] POS0 = WA'(POS_RESET);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_SRCH_A, ST_SRCH_B, ST_LOOK_A, ST_LOOK_B, ST_MUL,
    ST_UPD, ST_LZ, ST_LIT, ST_CP_A, ST_CP_B, ST_SEND
  } state_t;

  typedef enum logic [1:0] {P_TABLE, P_CODE, P_DEC} phase_t;
  typedef enum logic [1:0] {LZ_CTRL, LZ_LIT, LZ_OFS, LZ_REF} lz_t;

  state_t      state;
  phase_t      phase;
  lz_t         lz_mode;
  logic [31:0] output_limit;
  logic [15:0] freq_total;
  logic [31:0] coder_low, coder_range, coder_code;
  logic [WA-1:0] window_pos;
  logic [WA:0]   wcount;
  logic [7:0]  flag_byte, offset_low;
  logic [2:0]  flag_bit;
  logic [8:0]  load_count;
  logic [31:0] emitted_count;
  logic        halted, norm_stage;
  out_item_t   res_pend;

  logic [31:0] dq, drem, dden;
  logic [4:0]  dcnt;
  logic        div_second;
  logic [31:0] scale, prod;
  logic [15:0] off, below;
  logic [7:0]  fr, lo, hi, sym;
  logic [4:0]  cp_k, cp_last;
  logic [WA-1:0] cp_src;
  logic        win_valid;

  logic [7:0]  freq_rd, freq_raddr, mid;
  logic [15:0] cum_rd, total_new;
  logic [7:0]  cum_raddr, win_rd, cp_byte;
  logic        freq_we, freq_re, cum_re, win_we, win_re;
  logic [WA-1:0] win_raddr;
  logic        slot_free, acc, shift_due;
  logic [32:0] rem_sh;
  logic        ge;
  logic [31:0] rem_nx, q_nx, low_neg;
  logic [47:0] mul_below;
  logic [39:0] mul_freq;
  logic [2:0]  fb_nx;
  lz_t         lz_adv;

  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = !(state == ST_IDLE && slot_free);
  assign acc       = in_valid && !in_stall;
  assign shift_due = (((coder_low + coder_range) ^ coder_low) < NORM_TOP);
  assign total_new = freq_total + {8'd0, in_item.data_byte};
  assign low_neg   = 32'd0 - coder_low;

  // One restoring division step per cycle.
  assign rem_sh = {drem, dq[31]};
  assign ge     = rem_sh >= {1'b0, dden};
  assign rem_nx = ge ? 32'(rem_sh - {1'b0, dden}) : rem_sh[31:0];
  assign q_nx   = {dq[30:0], ge};

  assign mid       = 8'(({1'b0, lo} + {1'b0, hi}) >> 1);
  assign mul_below = scale * below;
  assign mul_freq  = scale * fr;
  assign fb_nx     = flag_bit + 3'd1;
  assign lz_adv    = flag_byte[fb_nx] ? LZ_LIT : LZ_OFS;

  assign freq_we    = acc && !halted && phase == P_TABLE && in_item.kind == KIND_FREQ;
  assign freq_re    = state == ST_LOOK_A;
  assign freq_raddr = sym;
  assign cum_re     = state == ST_SRCH_A || state == ST_LOOK_A;
  assign cum_raddr  = (state == ST_SRCH_A) ? mid : sym - 8'd1;
  assign win_re     = state == ST_CP_A;
  assign win_raddr  = cp_src + WA'(cp_k);
  assign win_we     = slot_free && (state == ST_LIT || state == ST_CP_B);
  assign cp_byte    = (state == ST_LIT) ? sym : (win_valid ? win_rd : 8'd0);

  rcl_ram #(.WIDTH(8), .DEPTH(256)) u_freq (
    .clk(clk), .we(freq_we), .waddr(load_count[7:0]), .wdata(in_item.data_byte),
    .re(freq_re), .raddr(freq_raddr), .rdata(freq_rd)
  );

  rcl_ram #(.WIDTH(16), .DEPTH(256)) u_cum (
    .clk(clk), .we(freq_we), .waddr(load_count[7:0]), .wdata(total_new),
    .re(cum_re), .raddr(cum_raddr), .rdata(cum_rd)
  );

  rcl_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_win (
    .clk(clk), .we(win_we), .waddr(window_pos), .wdata(cp_byte),
    .re(win_re), .raddr(win_raddr), .rdata(win_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      phase         <= P_TABLE;
      lz_mode       <= LZ_CTRL;
      output_limit  <= '0;
      freq_total    <= '0;
      coder_low     <= '0;
      coder_range   <= '1;
      coder_code    <= '0;
      window_pos    <= POS0;
      wcount        <= '0;
      flag_byte     <= '0;
      flag_bit      <= '0;
      offset_low    <= '0;
      load_count    <= '0;
      emitted_count <= '0;
      halted        <= 1'b0;
      norm_stage    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        output_limit <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      // Every emitted byte goes into the window and counts toward the limit.
      if (win_we) begin
        window_pos <= window_pos + WA'(1);
        if (wcount != (WA+1)'(WINDOW_DEPTH)) begin
          wcount <= wcount + (WA+1)'(1);
        end
        if (emitted_count != 32'hFFFF_FFFF) begin
          emitted_count <= emitted_count + 32'd1;
        end
      end
      case (state)
        ST_IDLE: begin
          if (acc) begin
            out_valid <= 1'b1;
            out_item  <= mk_res(8'd0, 1'b0, 1'b1, STATUS_UNEXP);
            if (halted) begin
              out_item <= mk_res(8'd0, 1'b0, 1'b1,
                                 (freq_total == 16'd0) ? STATUS_EMPTY : STATUS_ZERO);
            end else begin
              case (phase)
                P_TABLE: begin
                  if (in_item.kind == KIND_FREQ) begin
                    freq_total <= total_new;
                    out_item   <= mk_res(8'd0, 1'b0, 1'b1, STATUS_OK);
                    if (load_count == 9'd255) begin
                      load_count <= '0;
                      if (total_new == 16'd0) begin
                        halted   <= 1'b1;
                        out_item <= mk_res(8'd0, 1'b0, 1'b1, STATUS_EMPTY);
                      end else begin
                        phase <= P_CODE;
                      end
                    end else begin
                      load_count <= load_count + 9'd1;
                    end
                  end
                end
                P_CODE: begin
                  if (in_item.kind == KIND_CODE) begin
                    coder_code <= {coder_code[23:0], in_item.data_byte};
                    out_item   <= mk_res(8'd0, 1'b0, 1'b1, STATUS_OK);
                    if (load_count == 9'd3) begin
                      load_count <= '0;
                      phase      <= P_DEC;
                    end else begin
                      load_count <= load_count + 9'd1;
                    end
                  end
                end
                default: begin
                  if (in_item.kind == KIND_CODE) begin
                    if (!norm_stage && shift_due) begin
                      coder_code  <= {coder_code[23:0], in_item.data_byte};
                      coder_range <= {coder_range[23:0], 8'd0};
                      coder_low   <= {coder_low[23:0], 8'd0};
                      out_item    <= mk_res(8'd0, 1'b0, 1'b1, STATUS_OK);
                    end else begin
                      norm_stage <= 1'b1;
                      if (coder_range < UNDERFLOW) begin
                        // Underflow: rebuild the range from the low end.
                        coder_code  <= {coder_code[23:0], in_item.data_byte};
                        coder_range <= {low_neg[23:0], 8'd0} & REBUILD_MASK;
                        coder_low   <= {coder_low[23:0], 8'd0};
                        out_item    <= mk_res(8'd0, 1'b0, 1'b1, STATUS_OK);
                      end
                    end
                  end else if (in_item.kind == KIND_STEP) begin
                    if (output_limit != 32'd0 && emitted_count >= output_limit) begin
                      out_item <= mk_res(8'd0, 1'b0, 1'b1, STATUS_LIMIT);
                    end else if (!norm_stage && shift_due) begin
                      out_item <= mk_res(8'd0, 1'b0, 1'b1, STATUS_NEED);
                    end else if (coder_range < UNDERFLOW) begin
                      norm_stage <= 1'b1;
                      out_item   <= mk_res(8'd0, 1'b0, 1'b1, STATUS_NEED);
                    end else begin
                      norm_stage <= 1'b0;
                      out_valid  <= 1'b0;
                      dq         <= coder_range;
                      drem       <= '0;
                      dden       <= {16'd0, freq_total};
                      dcnt       <= '0;
                      div_second <= 1'b0;
                      state      <= ST_DIV;
                    end
                  end
                end
              endcase
            end
          end
        end
        ST_DIV: begin
          dq   <= q_nx;
          drem <= rem_nx;
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd31) begin
            if (!div_second) begin
              if (q_nx == 32'd0) begin
                halted   <= 1'b1;
                res_pend <= mk_res(8'd0, 1'b0, 1'b1, STATUS_ZERO);
                state    <= ST_SEND;
              end else begin
                scale      <= q_nx;
                dq         <= coder_code - coder_low;
                drem       <= '0;
                dden       <= q_nx;
                div_second <= 1'b1;
              end
            end else begin
              // The offset is clamped to the last symbol's slot.
              off   <= (q_nx >= {16'd0, freq_total}) ? freq_total - 16'd1 : q_nx[15:0];
              lo    <= 8'd0;
              hi    <= 8'd255;
              state <= ST_SRCH_A;
            end
          end
        end
        ST_SRCH_A: begin
          state <= ST_SRCH_B;
        end
        ST_SRCH_B: begin
          // First entry whose cumulative count exceeds the offset.
          if (cum_rd > off) begin
            hi <= mid;
            if (lo == mid) begin
              sym   <= mid;
              state <= ST_LOOK_A;
            end else begin
              state <= ST_SRCH_A;
            end
          end else begin
            lo <= mid + 8'd1;
            if (mid + 8'd1 == hi) begin
              sym   <= hi;
              state <= ST_LOOK_A;
            end else begin
              state <= ST_SRCH_A;
            end
          end
        end
        ST_LOOK_A: begin
          state <= ST_LOOK_B;
        end
        ST_LOOK_B: begin
          below <= (sym == 8'd0) ? 16'd0 : cum_rd;
          fr    <= freq_rd;
          state <= ST_MUL;
        end
        ST_MUL: begin
          prod  <= mul_below[31:0];
          state <= ST_UPD;
        end
        ST_UPD: begin
          coder_low   <= coder_low + prod;
          coder_range <= mul_freq[31:0];
          state       <= ST_LZ;
        end
        ST_LZ: begin
          case (lz_mode)
            LZ_CTRL: begin
              flag_byte <= sym;
              flag_bit  <= 3'd0;
              lz_mode   <= sym[0] ? LZ_LIT : LZ_OFS;
              res_pend  <= mk_res(8'd0, 1'b0, 1'b1, STATUS_OK);
              state     <= ST_SEND;
            end
            LZ_LIT: begin
              state <= ST_LIT;
            end
            LZ_OFS: begin
              offset_low <= sym;
              lz_mode    <= LZ_REF;
              res_pend   <= mk_res(8'd0, 1'b0, 1'b1, STATUS_OK);
              state      <= ST_SEND;
            end
            default: begin
              cp_last <= {1'b0, sym[3:0]} + 5'd2;
              cp_src  <= WA'({sym[7:4], offset_low});
              cp_k    <= 5'd0;
              state   <= ST_CP_A;
            end
          endcase
        end
        ST_LIT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_item  <= mk_res(sym, 1'b1, 1'b1, STATUS_OK);
            flag_bit  <= fb_nx;
            lz_mode   <= (flag_bit == 3'd7) ? LZ_CTRL : lz_adv;
            state     <= ST_IDLE;
          end
        end
        ST_CP_A: begin
          // Entries outside the written span are read as zero.
          win_valid <= {1'b0, WA'(win_raddr - POS0)} < wcount;
          state     <= ST_CP_B;
        end
        ST_CP_B: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_item  <= mk_res(cp_byte, 1'b1, cp_k == cp_last, STATUS_OK);
            if (cp_k == cp_last) begin
              flag_bit <= fb_nx;
              lz_mode  <= (flag_bit == 3'd7) ? LZ_CTRL : lz_adv;
              state    <= ST_IDLE;
            end else begin
              cp_k  <= cp_k + 5'd1;
              state <= ST_CP_A;
            end
          end
        end
        ST_SEND: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_item  <= res_pend;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_CLK(a_div_nonzero, (state == ST_DIV) |-> (dden != 32'd0))
  `ASSERT_CLK(a_search_open, (state == ST_SRCH_A) |-> (lo < hi))
  `ASSERT_CLK(a_copy_len, (state == ST_CP_A) |-> (cp_k <= cp_last))
  `ASSERT_NEVER(a_fill_bound, wcount > (WA+1)'(WINDOW_DEPTH))
  `ASSERT_CLK(a_win_emit, win_we |=> out_valid && out_item.has_byte)

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the range coded LZSS decoder core.
`timescale 1ns / 1ps

module testbench;
  import rcl_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES   = 200;
  localparam logic [1:0] KIND_BAD = 2'd3;

  localparam logic [1:0] SH_TABLE = 2'd0;
  localparam logic [1:0] SH_CODE  = 2'd1;
  localparam logic [1:0] SH_DEC   = 2'd2;

  localparam logic [1:0] SH_LZ_CTRL = 2'd0;
  localparam logic [1:0] SH_LZ_LIT  = 2'd1;
  localparam logic [1:0] SH_LZ_OFS  = 2'd2;
  localparam logic [1:0] SH_LZ_REF  = 2'd3;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [31:0] cfg_data;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;

  range_coded_lzss_decoder_core DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int errors;
  int items_sent;
  int results_seen;
  int bytes_seen;

  // Decoder shadow state.
  logic [7:0]  sh_freq[256];
  logic [15:0] sh_cum[256];
  logic [31:0] sh_total;
  logic [31:0] sh_low, sh_range, sh_code;
  logic [7:0]  sh_window[4096];
  logic [11:0] sh_pos;
  logic [7:0]  sh_flags;
  logic [2:0]  sh_flag_bit;
  logic [1:0]  sh_lz;
  logic [7:0]  sh_off_low;
  int          sh_load;
  logic [31:0] sh_emitted;
  logic [1:0]  sh_phase;
  logic        sh_halted;
  logic        sh_stage;
  logic [31:0] sh_limit;
  logic [2:0]  last_status;

  task automatic reset_shadow();
    for (int i = 0; i < 256; i++) begin
      sh_freq[i[7:0]] = 8'd0;
      sh_cum[i[7:0]] = 16'd0;
    end
    for (int i = 0; i < 4096; i++) sh_window[i[11:0]] = 8'd0;
    sh_total = 0; sh_low = 0; sh_range = 32'hFFFF_FFFF; sh_code = 0;
    sh_pos = POS_RESET; sh_flags = 0; sh_flag_bit = 0; sh_lz = SH_LZ_CTRL; sh_off_low = 0;
    sh_load = 0; sh_emitted = 0; sh_phase = SH_TABLE; sh_halted = 0; sh_stage = 0;
    sh_limit = 0;
  endtask

  task automatic expect_result(logic [7:0] b, logic has, logic [2:0] st);
    out_item_t r;
    r.out_byte = b;
    r.has_byte = has;
    r.last = 1'b0;
    r.status = st;
    expected_results = {expected_results, r};
  endtask

  task automatic emit_decoded(logic [7:0] b);
    sh_window[sh_pos] = b;
    sh_pos = sh_pos + 12'd1;
    if (sh_emitted != 32'hFFFF_FFFF) sh_emitted = sh_emitted + 1;
    expect_result(b, 1'b1, STATUS_OK);
  endtask

  task automatic next_flag();
    if (sh_flag_bit == 3'd7) begin
      sh_flag_bit = 0;
      sh_lz = SH_LZ_CTRL;
    end else begin
      sh_flag_bit = sh_flag_bit + 3'd1;
      sh_lz = sh_flags[sh_flag_bit] ? SH_LZ_LIT : SH_LZ_OFS;
    end
  endtask

  function automatic logic norm_shift_due();
    return ((sh_low + sh_range) ^ sh_low) < NORM_TOP;
  endfunction

  // Work out the results of one item and queue them as expectations.
  task automatic decode_item(logic [1:0] kind, logic [7:0] b);
    int first;
    logic [31:0] scale, off, below;
    int s, len;
    logic [11:0] src;
    first = expected_results.size();
    if (sh_halted) begin
      expect_result(0, 0, sh_total == 0 ? STATUS_EMPTY : STATUS_ZERO);
    end else if (sh_phase == SH_TABLE) begin
      if (kind == KIND_FREQ) begin
        sh_freq[sh_load[7:0]] = b;
        sh_total = sh_total + b;
        sh_cum[sh_load[7:0]] = sh_total[15:0];
        sh_load++;
        if (sh_load >= 256) begin
          sh_load = 0;
          if (sh_total == 0) begin
            sh_halted = 1;
            expect_result(0, 0, STATUS_EMPTY);
          end else begin
            sh_phase = SH_CODE;
            expect_result(0, 0, STATUS_OK);
          end
        end else begin
          expect_result(0, 0, STATUS_OK);
        end
      end else begin
        expect_result(0, 0, STATUS_UNEXP);
      end
    end else if (sh_phase == SH_CODE) begin
      if (kind == KIND_CODE) begin
        sh_code = {sh_code[23:0], b};
        sh_load++;
        if (sh_load >= 4) begin
          sh_load = 0;
          sh_phase = SH_DEC;
        end
        expect_result(0, 0, STATUS_OK);
      end else begin
        expect_result(0, 0, STATUS_UNEXP);
      end
    end else if (kind == KIND_CODE) begin
      if (!sh_stage && norm_shift_due()) begin
        sh_code = {sh_code[23:0], b};
        sh_range = sh_range << 8;
        sh_low = sh_low << 8;
        expect_result(0, 0, STATUS_OK);
      end else begin
        sh_stage = 1;
        if (sh_range < UNDERFLOW) begin
          sh_code = {sh_code[23:0], b};
          sh_range = ((32'd0 - sh_low) << 8) & REBUILD_MASK;
          sh_low = sh_low << 8;
          expect_result(0, 0, STATUS_OK);
        end else begin
          expect_result(0, 0, STATUS_UNEXP);
        end
      end
    end else if (kind == KIND_STEP) begin
      if (sh_limit != 0 && sh_emitted >= sh_limit) begin
        expect_result(0, 0, STATUS_LIMIT);
      end else if (!sh_stage && norm_shift_due()) begin
        expect_result(0, 0, STATUS_NEED);
      end else if (sh_range < UNDERFLOW) begin
        sh_stage = 1;
        expect_result(0, 0, STATUS_NEED);
      end else begin
        scale = sh_range / sh_total;
        sh_stage = 0;
        if (scale == 0) begin
          sh_halted = 1;
          expect_result(0, 0, STATUS_ZERO);
        end else begin
          off = (sh_code - sh_low) / scale;
          if (off >= sh_total) off = sh_total - 1;
          s = 0;
          while (s < 255 && {16'd0, sh_cum[s[7:0]]} <= off) s++;
          below = (s == 0) ? 32'd0 : {16'd0, sh_cum[8'(s - 1)]};
          sh_low = sh_low + scale * below;
          sh_range = scale * {24'd0, sh_freq[s[7:0]]};
          case (sh_lz)
            SH_LZ_CTRL: begin
              sh_flags = s[7:0];
              sh_flag_bit = 0;
              sh_lz = s[0] ? SH_LZ_LIT : SH_LZ_OFS;
              expect_result(0, 0, STATUS_OK);
            end
            SH_LZ_LIT: begin
              emit_decoded(s[7:0]);
              next_flag();
            end
            SH_LZ_OFS: begin
              sh_off_low = s[7:0];
              sh_lz = SH_LZ_REF;
              expect_result(0, 0, STATUS_OK);
            end
            default: begin
              len = s[3:0] + 3;
              src = {s[7:4], sh_off_low};
              for (int k = 0; k < len; k++) emit_decoded(sh_window[src + k[11:0]]);
              next_flag();
            end
          endcase
        end
      end
    end else begin
      expect_result(0, 0, STATUS_UNEXP);
    end
    expected_results[expected_results.size()-1].last = 1'b1;
    last_status = expected_results[first].status;
  endtask

  task automatic send(logic [1:0] kind, logic [7:0] b);
    in_item_t it;
    it.kind = kind;
    it.data_byte = b;
    pending_items = {pending_items, it};
    items_sent++;
    decode_item(kind, b);
  endtask

  // Mostly well-formed decoding: a code byte in most cases when the coder asks for one.
  task automatic run_decode(int count);
    for (int i = 0; i < count; i++) begin
      if (last_status == STATUS_NEED && $urandom_range(0, 15) != 0)
        send(KIND_CODE, 8'($urandom));
      else if ($urandom_range(0, 9) == 0)
        send(2'($urandom_range(0, 3)), 8'($urandom));
      else
        send(KIND_STEP, 8'($urandom));
    end
  endtask

  function automatic int draw_wait();
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
  endfunction

  // Input side.
  int in_gap;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_item <= '0;
      in_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_items.size() > 0) begin
        in_item <= pending_items.pop_front();
        in_valid <= 1'b1;
        in_gap <= draw_wait();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic report(string what, out_item_t got, out_item_t want);
    errors++;
    $display("MISMATCH %s: got byte %h has %b last %b st %0d, want byte %h has %b last %b st %0d",
             what, got.out_byte, got.has_byte, got.last, got.status,
             want.out_byte, want.has_byte, want.last, want.status);
  endtask

  // Output side.
  int out_hold;
  int next_hold;
  out_item_t want;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_hold <= 0;
    end else begin
      next_hold = out_hold;
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_item.has_byte) bytes_seen++;
        if (expected_results.size() == 0) begin
          report("unexpected result", out_item, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_item.out_byte !== want.out_byte) report("out_byte", out_item, want);
          else if (out_item.has_byte !== want.has_byte) report("has_byte", out_item, want);
          else if (out_item.last !== want.last) report("last", out_item, want);
          else if (out_item.status !== want.status) report("status", out_item, want);
        end
        next_hold = draw_wait();
      end else if (next_hold != 0) begin
        next_hold = next_hold - 1;
      end
      out_hold <= next_hold;
      out_stall <= (next_hold != 0);
    end
  end

  // A run that stops making progress while work is outstanding is a failure.
  int idle_cycles;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (pending_items.size() == 0 && !in_valid && expected_results.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sh_limit = value;
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    bytes_seen = 0;
    last_status = STATUS_OK;
    reset_shadow();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_limit(32'd0);

    // Wrong kinds while the table loads.
    send(KIND_STEP, 8'h00);
    send(KIND_CODE, 8'hFF);
    send(KIND_BAD, 8'hA5);
    // A sparse table usually keeps the total well below the smallest coder range.
    for (int i = 0; i < 256; i++) begin
      if (i == 7 || i == 200) send(KIND_FREQ, 8'hFF);
      else if (i == 0 || $urandom_range(0, 1) == 0) send(KIND_FREQ, 8'h00);
      else send(KIND_FREQ, 8'($urandom_range(1, 31)));
    end
    send(KIND_FREQ, 8'h5A);
    send(KIND_STEP, 8'h00);
    send(KIND_BAD, 8'h00);
    send(KIND_CODE, 8'h00);
    send(KIND_CODE, 8'hFF);
    send(KIND_CODE, 8'($urandom));
    send(KIND_CODE, 8'($urandom));
    send(KIND_CODE, 8'h00);
    send(KIND_BAD, 8'hFF);
    run_decode(12);
    wait_drained();

    // A limit six bytes ahead, so it can be reached inside the phase.
    write_limit(sh_emitted + 32'd6);
    run_decode(5);
    wait_drained();

    write_limit(32'd1);
    run_decode(3);
    wait_drained();

    write_limit(32'hFFFF_FFFF);
    run_decode(6);
    wait_drained();

    $display("Sent %0d items, checked %0d results carrying %0d bytes.",
             items_sent, results_seen, bytes_seen);
    $display("Limit settings 0, near, 1 and all ones; %0d mismatches.", errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/rcl_pkg.sv
src/rcl_ram.sv
src/range_coded_lzss_decoder_core.sv
tb/sv/testbench.sv
